@@ hdl/u2u8_pkg.sv @@
// Shared types and constants of the UTF-16 to UTF-8 encoder.
`default_nettype none

package u2u8_pkg;

    localparam int UNIT_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int JOB_BYTES   = 6;
    localparam int COUNT_W     = 3;
    localparam int QUEUE_DEPTH = 2;

    // Top six bits of a code unit that mark a high or a low surrogate.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    // Supplementary code points start at this offset.
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // UTF-8 bytes of the replacement character U+FFFD.
    localparam logic [BYTE_W-1:0] REPL_BYTE0 = 8'hEF;
    localparam logic [BYTE_W-1:0] REPL_BYTE1 = 8'hBF;
    localparam logic [BYTE_W-1:0] REPL_BYTE2 = 8'hBD;
    localparam logic [COUNT_W-1:0] REPL_COUNT = 3'd3;

    // Work for the back end: the bytes of one item, lowest index sent first.
    typedef struct packed {
        logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]               count;
        logic                             eob;
    } job_t;

endpackage

`default_nettype wire

@@ hdl/u2u8_front.sv @@
// Front end: accepts code units, tracks a pending high surrogate and builds byte jobs.
`default_nettype none

module u2u8_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [u2u8_pkg::UNIT_W-1:0]     s_tdata,   // [15:0] code_unit
    input  wire logic                            s_tlast,   // end_of_block
    input  wire logic                            q_full,
    output logic                                 q_push,
    output u2u8_pkg::job_t                       q_job
);

    logic [9:0]  held_bits_reg;
    logic [9:0]  held_bits_next;
    logic        pending_reg;
    logic        pending_next;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic [20:0] pair_cp;
    logic [3:0][u2u8_pkg::BYTE_W-1:0] main_bytes;
    logic [u2u8_pkg::COUNT_W-1:0]     main_count;
    logic        prefix_repl;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_high  = (s_tdata[15:10] == u2u8_pkg::SURR_HIGH_TAG);
    assign is_low   = (s_tdata[15:10] == u2u8_pkg::SURR_LOW_TAG);
    assign pair_cp  = {1'b0, held_bits_reg, s_tdata[9:0]} + u2u8_pkg::SUPP_BASE;

    // Bytes of the unit itself, or of the completed pair, or of U+FFFD for an orphan low.
    always_comb begin
        main_bytes = '0;
        main_count = '0;
        if (is_low) begin
            if (pending_reg) begin
                main_bytes[0] = {5'b11110, pair_cp[20:18]};
                main_bytes[1] = {2'b10, pair_cp[17:12]};
                main_bytes[2] = {2'b10, pair_cp[11:6]};
                main_bytes[3] = {2'b10, pair_cp[5:0]};
                main_count    = 3'd4;
            end else begin
                main_bytes[0] = u2u8_pkg::REPL_BYTE0;
                main_bytes[1] = u2u8_pkg::REPL_BYTE1;
                main_bytes[2] = u2u8_pkg::REPL_BYTE2;
                main_count    = u2u8_pkg::REPL_COUNT;
            end
        end else if (s_tdata[15:7] == 9'd0) begin
            main_bytes[0] = s_tdata[7:0];
            main_count    = 3'd1;
        end else if (s_tdata[15:11] == 5'd0) begin
            main_bytes[0] = {3'b110, s_tdata[10:6]};
            main_bytes[1] = {2'b10, s_tdata[5:0]};
            main_count    = 3'd2;
        end else begin
            main_bytes[0] = {4'b1110, s_tdata[15:12]};
            main_bytes[1] = {2'b10, s_tdata[11:6]};
            main_bytes[2] = {2'b10, s_tdata[5:0]};
            main_count    = 3'd3;
        end
    end

    // A BMP unit after an unpaired high surrogate is preceded by U+FFFD.
    assign prefix_repl = pending_reg && !is_low;

    always_comb begin
        q_job     = '0;
        q_job.eob = s_tlast;
        if (prefix_repl) begin
            q_job.bytes[0] = u2u8_pkg::REPL_BYTE0;
            q_job.bytes[1] = u2u8_pkg::REPL_BYTE1;
            q_job.bytes[2] = u2u8_pkg::REPL_BYTE2;
            q_job.bytes[3] = main_bytes[0];
            q_job.bytes[4] = main_bytes[1];
            q_job.bytes[5] = main_bytes[2];
            q_job.count    = u2u8_pkg::REPL_COUNT + main_count;
        end else begin
            q_job.bytes[0] = main_bytes[0];
            q_job.bytes[1] = main_bytes[1];
            q_job.bytes[2] = main_bytes[2];
            q_job.bytes[3] = main_bytes[3];
            q_job.count    = main_count;
        end
    end

    // A high surrogate is only stored; every other unit produces a job.
    assign q_push = accept && !is_high;

    always_comb begin
        held_bits_next = held_bits_reg;
        pending_next   = pending_reg;
        if (accept) begin
            pending_next = is_high;
            if (is_high) begin
                held_bits_next = s_tdata[9:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bits_reg <= '0;
            pending_reg   <= 1'b0;
        end else begin
            held_bits_reg <= held_bits_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/u2u8_queue.sv @@
// Short queue of byte jobs between the front end and the back end.
`default_nettype none

module u2u8_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire u2u8_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output u2u8_pkg::job_t      head_job
);

    localparam int DEPTH = u2u8_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u8_pkg::job_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ hdl/u2u8_back.sv @@
// Back end: an output register sends job bytes one per cycle when m_tready allows.
`default_nettype none

module u2u8_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire u2u8_pkg::job_t                q_job,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [u2u8_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] utf8_byte
    output logic                               m_tlast,   // last_of_run
    output logic                               m_tuser    // block_end
);

    u2u8_pkg::job_t               job_reg;
    u2u8_pkg::job_t               job_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic [u2u8_pkg::COUNT_W-1:0] idx_reg;
    logic [u2u8_pkg::COUNT_W-1:0] idx_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [u2u8_pkg::BYTE_W-1:0]  out_byte_reg;
    logic [u2u8_pkg::BYTE_W-1:0]  out_byte_next;
    logic                         out_last_reg;
    logic                         out_last_next;
    logic                         out_eob_reg;
    logic                         out_eob_next;

    logic                         load;
    logic                         is_last;

    assign load    = !out_valid_reg || m_tready;
    assign is_last = (idx_reg == job_reg.count - 1'b1);
    // The next job is taken as soon as the current one hands over its final byte.
    assign q_pop   = q_valid && (!busy_reg || (load && is_last));

    always_comb begin
        job_next       = job_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_eob_next   = out_eob_reg;
        if (load) begin
            out_valid_next = busy_reg;
            out_byte_next  = job_reg.bytes[idx_reg];
            out_last_next  = is_last;
            out_eob_next   = is_last && job_reg.eob;
            if (busy_reg) begin
                idx_next = idx_reg + 1'b1;
                if (is_last) begin
                    busy_next = 1'b0;
                end
            end
        end
        if (q_pop) begin
            job_next  = q_job;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_eob_reg  <= out_eob_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_eob_reg;

`ifndef SYNTH
    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg < job_reg.count))
        else $error("byte index ran past the end of the job");

    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (job_reg.count != '0))
        else $error("back end holds a job without bytes");

    a_eob_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("block end shown on a byte that is not the last of its item");
`endif

endmodule

`default_nettype wire

@@ hdl/utf16_to_utf8_encoder_unit.sv @@
// Top level of the UTF-16 to UTF-8 encoder: front end, job queue and byte sender.
// The first byte of an item passes through the job queue, the job register and the output register
// before it appears on m_tdata. Throughput: one byte per cycle at the output while m_tready does not
// stall it; an item yields one to six bytes, and a high surrogate yields no byte.
// The byte sender's one-byte-per-cycle output register sets that rate.
// Reset: aresetn is synchronous and active low; it drops the pending surrogate and all queued items.
`default_nettype none

module utf16_to_utf8_encoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] code_unit
    input  wire logic        s_tlast,   // end_of_block
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] utf8_byte
    output logic             m_tlast,   // last_of_run
    output logic             m_tuser    // block_end
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    u2u8_pkg::job_t push_job;
    u2u8_pkg::job_t head_job;

    u2u8_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    u2u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    u2u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
